### src/xvtd_pkg.sv
// shared types, character codes and lookup functions for the attribute value text decoder
// no dependencies
`default_nettype none

package xvtd_pkg;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_US     = 8'h53;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7a;

  typedef enum logic [2:0] {
    MODE_START0 = 3'd0,
    MODE_START1 = 3'd1,
    MODE_TEXT   = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_B64    = 3'd4,
    MODE_B64PAD = 3'd5,
    MODE_B64END = 3'd6,
    MODE_DEAD   = 3'd7
  } mode_t;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_BS   = 2'd1;
  localparam logic [1:0] ESC_OCT1 = 2'd2;
  localparam logic [1:0] ESC_OCT2 = 2'd3;

  // all results caused by one input beat
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RES-1:0][7:0]      data;
    logic [MAX_RES-1:0]           has;
    logic [MAX_RES-1:0]           bad;
    logic                         eov;
  } bundle_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      t = b - CH_ZERO;
      return {1'b1, t[3:0]};
    end
    if (b >= CH_LA && b <= CH_LF) begin
      t = b - CH_LA + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] b64_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= CH_UA && b <= CH_UZ) begin
      t = b - CH_UA;
      return {1'b1, t[5:0]};
    end
    if (b >= CH_LA && b <= CH_LZ) begin
      t = b - CH_LA + 8'd26;
      return {1'b1, t[5:0]};
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      t = b - CH_ZERO + 8'd52;
      return {1'b1, t[5:0]};
    end
    if (b == CH_PLUS)  return {1'b1, 6'd62};
    if (b == CH_SLASH) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

endpackage

`default_nettype wire

### src/xattr_value_text_decoder.sv
// top level of the attribute value text decoder: front end, bundle queue, serializer
// depends on xvtd_pkg, xvtd_front, xvtd_queue, xvtd_back
// path: the bundle built from a text beat is registered in the queue before its result beats are offered
// throughput: one text beat per cycle unless the queue is full; results leave one at a time
// the four-entry queue absorbs bursts (base64 groups give three bytes per four beats)
// reset: synchronous, clears mode, escape and group state and empties the queue
`default_nettype none

module xattr_value_text_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  input  wire logic       enclosed,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            has_byte,
  output logic            value_end,
  output logic            bad_encoding
);
  import xvtd_pkg::*;

  // bundles that cause no result (held escapes, half hex pairs) never enter the queue
  logic    push, pop, q_full, head_valid;
  bundle_t push_data, head;

  // front end: runs the per-value decode state one text beat per cycle unless the queue is full
  xvtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .enclosed   (enclosed),
    .in_stall   (in_stall),
    .push       (push),
    .push_data  (push_data)
  );

  // queue lets the front keep going while the output side stalls
  xvtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // serializer: one result beat per cycle from the head bundle while out_stall is low
  xvtd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .out_stall    (out_stall),
    .pop          (pop),
    .out_valid    (out_valid),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .value_end    (value_end),
    .bad_encoding (bad_encoding)
  );

endmodule

`default_nettype wire

### src/xvtd_front.sv
// front end: accepts text beats, tracks the decode mode and builds a result bundle per beat
// depends on xvtd_pkg
`default_nettype none

module xvtd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             q_full,
  input  wire logic [7:0]       text_byte,
  input  wire logic             final_byte,
  input  wire logic             enclosed,
  output logic                  in_stall,
  output logic                  push,
  output xvtd_pkg::bundle_t     push_data
);
  import xvtd_pkg::*;

  mode_t       mode, mode_next;
  logic [1:0]  esc, esc_next;
  logic [8:0]  oct, oct_next;
  logic [4:0]  hexn, hexn_next;
  logic [17:0] b64bits, b64bits_next;
  logic [1:0]  b64cnt, b64cnt_next;
  bundle_t     res;
  logic        accept;

  function automatic void put(inout bundle_t r, input logic [7:0] b, input logic h,
                              input logic bad);
    if (r.cnt != 2'd3) begin
      r.data[r.cnt] = h ? b : 8'd0;
      r.has[r.cnt]  = h;
      r.bad[r.cnt]  = bad;
      r.cnt         = r.cnt + 2'd1;
    end
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic       do_text, tq, skip, last, is_oct;
    logic [7:0] b;
    logic [4:0] hv;
    logic [6:0] bv;
    b         = text_byte;
    last      = final_byte;
    is_oct    = (b >= CH_ZERO) && (b <= CH_SEVEN);
    hv        = hex_val(b);
    bv        = b64_val(b);
    do_text   = 1'b0;
    tq        = 1'b0;
    skip      = 1'b0;
    res       = '0;
    mode_next = mode;
    esc_next  = esc;
    oct_next  = oct;
    hexn_next = hexn;
    b64bits_next = b64bits;
    b64cnt_next  = b64cnt;

    case (mode)
      MODE_START0: begin
        if (enclosed) begin
          mode_next = MODE_TEXT;
        end else if (b == CH_ZERO && !last) begin
          mode_next = MODE_START1;
        end else begin
          mode_next = MODE_TEXT;
          do_text   = 1'b1;
        end
      end
      MODE_START1: begin
        if (b == CH_LX || b == CH_UX) begin
          mode_next = MODE_HEX;
        end else if (b == CH_LS || b == CH_US) begin
          mode_next = MODE_B64;
        end else begin
          mode_next = MODE_TEXT;
          put(res, CH_ZERO, 1'b1, 1'b0);
          do_text = 1'b1;
          tq      = enclosed;
        end
      end
      MODE_TEXT: begin
        do_text = 1'b1;
        tq      = enclosed;
      end
      MODE_HEX: begin
        if (hexn[4]) begin
          if (!hv[4]) begin
            mode_next = MODE_DEAD;
            put(res, 8'd0, 1'b0, 1'b1);
          end else begin
            put(res, {hexn[3:0], hv[3:0]}, 1'b1, 1'b0);
            hexn_next = 5'd0;
          end
        end else if (!last) begin
          if (!hv[4]) begin
            mode_next = MODE_DEAD;
            put(res, 8'd0, 1'b0, 1'b1);
          end else begin
            hexn_next = {1'b1, hv[3:0]};
          end
        end
      end
      MODE_B64, MODE_B64PAD, MODE_B64END: begin
        if (mode == MODE_B64END) begin
          mode_next = MODE_DEAD;
          put(res, 8'd0, 1'b0, 1'b1);
        end else if (mode == MODE_B64PAD) begin
          if (b != CH_EQUALS) begin
            mode_next = MODE_DEAD;
            put(res, 8'd0, 1'b0, 1'b1);
          end else begin
            put(res, b64bits[11:4], 1'b1, 1'b0);
            mode_next = MODE_B64END;
          end
        end else if (b == CH_EQUALS) begin
          if (b64cnt == 2'd2 && !last) begin
            mode_next = MODE_B64PAD;
          end else if (b64cnt == 2'd3) begin
            put(res, b64bits[17:10], 1'b1, 1'b0);
            put(res, b64bits[9:2], 1'b1, 1'b0);
            mode_next = MODE_B64END;
          end else begin
            mode_next = MODE_DEAD;
            put(res, 8'd0, 1'b0, 1'b1);
          end
        end else if (!bv[6]) begin
          mode_next = MODE_DEAD;
          put(res, 8'd0, 1'b0, 1'b1);
        end else if (b64cnt == 2'd3) begin
          put(res, b64bits[17:10], 1'b1, 1'b0);
          put(res, b64bits[9:2], 1'b1, 1'b0);
          put(res, {b64bits[1:0], bv[5:0]}, 1'b1, 1'b0);
          b64bits_next = 18'd0;
          b64cnt_next  = 2'd0;
        end else begin
          b64bits_next = {b64bits[11:0], bv[5:0]};
          b64cnt_next  = b64cnt + 2'd1;
          if (last) begin
            mode_next = MODE_DEAD;
            put(res, 8'd0, 1'b0, 1'b1);
          end
        end
      end
      default: ;
    endcase

    if (do_text) begin
      if (!(last && tq)) begin
        // escape handling for a regular character
        if (esc_next == ESC_BS) begin
          if (b == CH_BSLASH || b == CH_DQUOTE) begin
            put(res, b, 1'b1, 1'b0);
            esc_next = ESC_NONE;
            skip     = 1'b1;
          end else if (is_oct) begin
            oct_next = {6'd0, b[2:0]};
            esc_next = ESC_OCT1;
            skip     = 1'b1;
          end else begin
            put(res, CH_BSLASH, 1'b1, 1'b0);
            esc_next = ESC_NONE;
          end
        end else if (esc_next == ESC_OCT1 || esc_next == ESC_OCT2) begin
          if (is_oct) begin
            oct_next = {oct_next[5:0], b[2:0]};
            if (esc_next == ESC_OCT2) begin
              put(res, oct_next[7:0], 1'b1, 1'b0);
              oct_next = 9'd0;
              esc_next = ESC_NONE;
            end else begin
              esc_next = ESC_OCT2;
            end
            skip = 1'b1;
          end else begin
            put(res, oct_next[7:0], 1'b1, 1'b0);
            oct_next = 9'd0;
            esc_next = ESC_NONE;
          end
        end
        if (!skip) begin
          if (b == CH_BSLASH) esc_next = ESC_BS;
          else                put(res, b, 1'b1, 1'b0);
        end
      end else if (esc_next == ESC_BS) begin
        // closing quote taken as the escaped character
        put(res, b, 1'b1, 1'b0);
        esc_next = ESC_NONE;
      end
      if (last) begin
        if (esc_next == ESC_BS)      put(res, CH_BSLASH, 1'b1, 1'b0);
        else if (esc_next != ESC_NONE) put(res, oct_next[7:0], 1'b1, 1'b0);
        esc_next = ESC_NONE;
        oct_next = 9'd0;
      end
    end

    if (last) begin
      if (res.cnt == 2'd0) put(res, 8'd0, 1'b0, mode_next == MODE_DEAD);
      res.eov      = 1'b1;
      mode_next    = MODE_START0;
      esc_next     = ESC_NONE;
      oct_next     = 9'd0;
      hexn_next    = 5'd0;
      b64bits_next = 18'd0;
      b64cnt_next  = 2'd0;
    end
  end

  assign push      = accept && (res.cnt != 2'd0);
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_START0;
      esc     <= ESC_NONE;
      oct     <= 9'd0;
      hexn    <= 5'd0;
      b64bits <= 18'd0;
      b64cnt  <= 2'd0;
    end else if (accept) begin
      mode    <= mode_next;
      esc     <= esc_next;
      oct     <= oct_next;
      hexn    <= hexn_next;
      b64bits <= b64bits_next;
      b64cnt  <= b64cnt_next;
    end
  end

endmodule

`default_nettype wire

### src/xvtd_queue.sv
// short bundle queue between the front end and the result serializer
// depends on xvtd_pkg
`default_nettype none

module xvtd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire xvtd_pkg::bundle_t push_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output xvtd_pkg::bundle_t      head
);
  import xvtd_pkg::*;

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_pop;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/xvtd_back.sv
// back end: walks the head bundle and hands out one result beat at a time
// depends on xvtd_pkg
`default_nettype none

module xvtd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire xvtd_pkg::bundle_t head,
  input  wire logic              out_stall,
  output logic                   pop,
  output logic                   out_valid,
  output logic [7:0]             data_byte,
  output logic                   has_byte,
  output logic                   value_end,
  output logic                   bad_encoding
);
  import xvtd_pkg::*;

  logic [1:0] sub;
  logic       last_sub;
  logic       take;

  assign out_valid    = head_valid;
  assign last_sub     = (sub == head.cnt - 2'd1);
  assign take         = out_valid && !out_stall;
  assign pop          = take && last_sub;
  assign data_byte    = head.data[sub];
  assign has_byte     = head.has[sub];
  assign bad_encoding = head.bad[sub];
  assign value_end    = head.eov && last_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (take) begin
      sub <= last_sub ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

`default_nettype wire

### src/xvtd_checker.sv
// port-level checks for the attribute value text decoder, bound to the top level
// depends on xattr_value_text_decoder ports only
`default_nettype none

module xvtd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] text_byte,
  input wire logic       final_byte,
  input wire logic       enclosed,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] data_byte,
  input wire logic       has_byte,
  input wire logic       value_end,
  input wire logic       bad_encoding
);

  // a held result beat stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(has_byte)
      && $stable(value_end) && $stable(bad_encoding))
    else $error("result beat changed while stalled");

  // a stalled text beat stays offered with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(text_byte) && $stable(final_byte)
      && $stable(enclosed))
    else $error("text beat changed while stalled");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // an empty result carries a zero byte
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> data_byte == 8'd0)
    else $error("data byte set on an empty result");

  // an error beat never carries data
  a_bad_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_encoding |-> !has_byte)
    else $error("error beat carries a byte");

endmodule

bind xattr_value_text_decoder xvtd_checker u_xvtd_checker (.*);

`default_nettype wire
